FILE: hdl/rotated_bilinear_sampler_macros.svh
// Assertion macros for the rotated bilinear sampler.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ROTATED_BILINEAR_SAMPLER_MACROS_SVH
`define ROTATED_BILINEAR_SAMPLER_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define RBS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rbs_pkg.sv
// Shared types and constants of the rotated bilinear sampler.
// No dependencies.
package rbs_pkg;
	localparam int PIX_W     = 8;
	localparam int FRAC_BITS = 8;
	localparam int TRIG_BITS = 14;
	localparam int BANK_AW   = 14;

	typedef enum logic [1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_COS  = 2'd2,
		REG_SIN  = 2'd3
	} reg_idx_t;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef logic [PIX_W-1:0]   pixel_t;
	typedef logic [BANK_AW-1:0] bank_addr_t;
endpackage

FILE: hdl/rotated_bilinear_sampler.sv
// Top level of the rotated bilinear sampler: rotation pipeline, banked store, blend.
// Depends on rbs_pkg, rbs_bank_mem and rotated_bilinear_sampler_macros.svh.
//
// Usage: the input channel (in_valid/in_stall) takes one word per cycle when
// not stalled. A write word (op 0) loads one pixel; a sample word (op 1) gives
// a point with eight fraction bits that is rotated about the image center and
// interpolated. The output channel (out_valid/out_stall) returns one word per
// sample word, in order; write words return nothing. A rejected point gives
// out_of_range 1 and a value of 0. Throughput is one word per cycle while no
// output word is held by out_stall, set by the four-bank store, which yields
// all four neighbors at once.
// The configuration channel (cfg_valid/cfg_ready) is always ready and writes
// image_rows, image_cols, cos_angle and sin_angle by index; write it only idle.
// Reset clears all valid bits and loads 256 x 256 with an angle of zero; the
// pixel store is not cleared. When out_stall holds a waiting word, the whole
// pipeline freezes and in_stall rises in the same cycle; nothing is lost.
module rotated_bilinear_sampler
	import rbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [7:0]         write_row,
	input  logic [7:0]         write_col,
	input  logic [7:0]         write_pixel,
	input  logic signed [16:0] query_first,
	input  logic signed [16:0] query_second,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         sample_value,
	output logic               out_of_range
);
	`include "rotated_bilinear_sampler_macros.svh"

	logic [8:0]         image_rows_q, image_cols_q;
	logic signed [15:0] cos_q, sin_q;
	logic [8:0]         rows, cols;
	logic [15:0]        cr, cc;
	logic               adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= 9'd256;
			image_cols_q <= 9'd256;
			cos_q        <= 16'sd16384;
			sin_q        <= 16'sd0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROWS: image_rows_q <= cfg_data[8:0];
				REG_COLS: image_cols_q <= cfg_data[8:0];
				REG_COS:  cos_q        <= cfg_data;
				REG_SIN:  sin_q        <= cfg_data;
				default:  ;
			endcase
		end
	end

	assign rows = (image_rows_q > 9'd256) ? 9'd256 : image_rows_q;
	assign cols = (image_cols_q > 9'd256) ? 9'd256 : image_cols_q;
	assign cr   = {rows, 7'd0};
	assign cc   = {cols, 7'd0};

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: offsets from the center.
	logic               v_s1, op_s1;
	logic [7:0]         wr_s1, wc_s1, wp_s1;
	logic signed [17:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= op;
			wr_s1 <= write_row;
			wc_s1 <= write_col;
			wp_s1 <= write_pixel;
			dx_s1 <= $signed({query_first[16], query_first}) - $signed({2'b00, cr});
			dy_s1 <= $signed({query_second[16], query_second}) - $signed({2'b00, cc});
		end
	end

	// Stage 2: rotation products.
	logic               v_s2, op_s2;
	logic [7:0]         wr_s2, wc_s2, wp_s2;
	logic signed [33:0] xc_s2, ys_s2, yc_s2, xs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_s1;
			wr_s2 <= wr_s1;
			wc_s2 <= wc_s1;
			wp_s2 <= wp_s1;
			xc_s2 <= dx_s1 * cos_q;
			ys_s2 <= dy_s1 * sin_q;
			yc_s2 <= dy_s1 * cos_q;
			xs_s2 <= dx_s1 * sin_q;
		end
	end

	// Stage 3: rotated point back in image coordinates.
	logic               v_s3, op_s3;
	logic [7:0]         wr_s3, wc_s3, wp_s3;
	logic signed [21:0] r_s3, c_s3;
	logic signed [34:0] sum_r, sum_c;

	assign sum_r = $signed({xc_s2[33], xc_s2}) + $signed({ys_s2[33], ys_s2});
	assign sum_c = $signed({yc_s2[33], yc_s2}) - $signed({xs_s2[33], xs_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3 <= op_s2;
			wr_s3 <= wr_s2;
			wc_s3 <= wc_s2;
			wp_s3 <= wp_s2;
			r_s3  <= $signed({sum_r[34], sum_r[34:TRIG_BITS]}) + $signed({6'd0, cr});
			c_s3  <= $signed({sum_c[34], sum_c[34:TRIG_BITS]}) + $signed({6'd0, cc});
		end
	end

	// Range test, bank addressing and the store access.
	logic signed [9:0]  rows_m1, cols_m1;
	logic signed [21:0] hi_r, hi_c;
	logic               oor;
	logic [7:0]         ii, jj, ii1, jj1;
	logic [7:0]         row_b [2];
	logic [7:0]         col_b [2];
	pixel_t             rd [4];

	assign rows_m1 = $signed({1'b0, rows}) - 10'sd1;
	assign cols_m1 = $signed({1'b0, cols}) - 10'sd1;
	assign hi_r    = {{4{rows_m1[9]}}, rows_m1, 8'd0};
	assign hi_c    = {{4{cols_m1[9]}}, cols_m1, 8'd0};
	assign oor     = (r_s3 < 22'sd256) || (r_s3 >= hi_r) ||
	                 (c_s3 < 22'sd256) || (c_s3 >= hi_c);
	assign ii  = r_s3[15:8];
	assign jj  = c_s3[15:8];
	assign ii1 = ii + 8'd1;
	assign jj1 = jj + 8'd1;

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			row_b[p] = (ii[0] == p[0]) ? ii : ii1;
			col_b[p] = (jj[0] == p[0]) ? jj : jj1;
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		rbs_bank_mem u_bank (
			.clk     (clk),
			.en      (adv),
			.wr_en   (adv && v_s3 && (op_s3 == OP_WRITE) &&
			          (wr_s3[0] == 1'(b / 2)) && (wc_s3[0] == 1'(b % 2))),
			.wr_addr ({wr_s3[7:1], wc_s3[7:1]}),
			.wr_data (wp_s3),
			.rd_addr ({row_b[b/2][7:1], col_b[b%2][7:1]}),
			.rd_data (rd[b])
		);
	end

	// Stage 4: neighbor pixels arrive from the banks.
	logic       v_s4, oor_s4, i0_s4, j0_s4;
	logic [7:0] fa_s4, fb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3 && (op_s3 == OP_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s4 <= oor;
			i0_s4  <= ii[0];
			j0_s4  <= jj[0];
			fa_s4  <= r_s3[7:0];
			fb_s4  <= c_s3[7:0];
		end
	end

	// Stage 5: blend along rows.
	pixel_t      p00, p10, p01, p11;
	logic [8:0]  ga;
	logic        v_s5, oor_s5;
	logic [7:0]  fb_s5;
	logic [16:0] sa_s5, sb_s5;

	assign p00 = rd[{i0_s4, j0_s4}];
	assign p10 = rd[{~i0_s4, j0_s4}];
	assign p01 = rd[{i0_s4, ~j0_s4}];
	assign p11 = rd[{~i0_s4, ~j0_s4}];
	assign ga  = 9'd256 - {1'b0, fa_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s5 <= oor_s4;
			fb_s5  <= fb_s4;
			sa_s5  <= 17'(p00 * ga) + 17'(p10 * fa_s4);
			sb_s5  <= 17'(p01 * ga) + 17'(p11 * fa_s4);
		end
	end

	// Output register: blend along columns and truncate.
	logic [8:0]  gb;
	logic [25:0] acc;

	assign gb  = 9'd256 - {1'b0, fb_s5};
	assign acc = 26'(sa_s5 * gb) + 26'(sb_s5 * fb_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_of_range <= oor_s5;
			sample_value <= oor_s5 ? 8'd0 : acc[23:16];
		end
	end

	`RBS_ASSERT_ALWAYS(a_oor_zero, !(out_valid && out_of_range) || (sample_value == 8'd0),
		"Rejected sample carries a nonzero value.")
	`RBS_ASSERT_ALWAYS(a_stall_cause, !in_stall || (out_valid && out_stall),
		"Input stalled without a held output word.")
	`RBS_ASSERT_NEXT(a_drain, v_s5 && !in_stall, out_valid,
		"Sample in the last stage did not reach the output.")
endmodule

FILE: hdl/rbs_bank_mem.sv
// One quarter of the pixel store, holding pixels of one row and column parity.
// Depends on rbs_pkg.
module rbs_bank_mem
	import rbs_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  logic       wr_en,
	input  bank_addr_t wr_addr,
	input  pixel_t     wr_data,
	input  bank_addr_t rd_addr,
	output pixel_t     rd_data
);
	pixel_t mem [2**BANK_AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
